[src/prab_pkg.sv]
// Shared types and constants for the packet register access bridge.
package prab_pkg;

   localparam logic [13:0] MAX_READ_WORDS = 14'd16382;

   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

   // result kinds on the output channel
   localparam logic [1:0] RES_REPLY = 2'd0;
   localparam logic [1:0] RES_WRITE = 2'd1;
   localparam logic [1:0] RES_READ  = 2'd2;

   // job kinds passed from the front to the back
   localparam logic [1:0] JOB_ECHO   = 2'd0;
   localparam logic [1:0] JOB_WRITE  = 2'd1;
   localparam logic [1:0] JOB_HEADER = 2'd2;
   localparam logic [1:0] JOB_RDATA  = 2'd3;

   localparam logic [7:0] CMD_ECHO   = 8'h00;
   localparam logic [7:0] CMD_ACCESS = 8'h01;
   localparam logic [7:0] REPLY_CMD  = 8'h01;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_val;
      logic        last;
      logic [31:0] address;
      logic [31:0] data;
      logic [13:0] count;
      logic [7:0]  flags;
      logic        request;
   } job_type;

endpackage

[src/prab_front.sv]
// Front end: parses packet bytes and read returns into jobs for the back end.
module prab_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              item_kind,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic [31:0]       read_data,
   output logic              job_push,
   output prab_pkg::job_type job
);
   import prab_pkg::*;

   localparam logic PH_PARSE = 1'b0;
   localparam logic PH_WAIT  = 1'b1;

   logic [15:0] pos_ff, pos_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [1:0]  aflags_ff, aflags_in;
   logic [7:0]  fbyte_ff, fbyte_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] len_ff, len_in;
   logic [23:0] wa_ff, wa_in;
   logic [13:0] written_ff, written_in;
   logic [13:0] remain_ff, remain_in;
   logic        phase_ff, phase_in;

   logic [15:0] count_raw;
   logic [15:0] len_minus;
   logic [13:0] total;
   logic [31:0] addr_step;

   always_comb begin
      pos_in     = pos_ff;
      cmd_in     = cmd_ff;
      aflags_in  = aflags_ff;
      fbyte_in   = fbyte_ff;
      addr_in    = addr_ff;
      len_in     = len_ff;
      wa_in      = wa_ff;
      written_in = written_ff;
      remain_in  = remain_ff;
      phase_in   = phase_ff;
      job_push   = 1'b0;
      job        = '0;
      count_raw  = '0;
      len_minus  = '0;
      total      = '0;
      addr_step  = '0;

      if (accept) begin
         if (item_kind) begin
            if (phase_ff == PH_WAIT && remain_ff != 14'd0) begin
               remain_in    = remain_ff - 14'd1;
               job_push     = 1'b1;
               job.kind     = JOB_RDATA;
               job.data     = read_data;
               job.address  = addr_ff;
               job.last     = (remain_in == 14'd0);
               job.request  = (remain_in != 14'd0);
               if (job.request) begin
                  if (aflags_ff[0]) addr_in = addr_ff + 32'd4;
               end else begin
                  phase_in = PH_PARSE;
               end
            end
         end else if (phase_ff == PH_PARSE) begin
            if (pos_ff == 16'd0) begin
               cmd_in     = in_byte;
               aflags_in  = '0;
               fbyte_in   = '0;
               addr_in    = '0;
               len_in     = '0;
               wa_in      = '0;
               written_in = '0;
               remain_in  = '0;
            end
            if (cmd_in == CMD_ECHO) begin
               job_push     = 1'b1;
               job.kind     = JOB_ECHO;
               job.byte_val = in_byte;
               job.last     = in_last;
            end else if (cmd_in == CMD_ACCESS) begin
               if (pos_ff == 16'd1 || pos_ff == 16'd2) begin
                  len_in = {len_ff[7:0], in_byte};
               end else if (pos_ff == 16'd3) begin
                  fbyte_in  = in_byte;
                  aflags_in = in_byte[7:6];
               end else if (pos_ff >= 16'd4 && pos_ff <= 16'd7) begin
                  addr_in = {addr_ff[23:0], in_byte};
               end else if (pos_ff >= 16'd8) begin
                  if (pos_ff == 16'd9) begin
                     count_raw = {wa_ff[7:0], in_byte};
                     remain_in = (count_raw > {2'b00, MAX_READ_WORDS}) ?
                                 MAX_READ_WORDS : count_raw[13:0];
                  end
                  // a word completes on every fourth data byte
                  if (aflags_ff[1] && pos_ff[1:0] == 2'b11) begin
                     len_minus = len_ff - 16'd5;
                     total     = (len_ff > 16'd5) ? len_minus[15:2] : 14'd0;
                     if (written_ff < total) begin
                        job_push    = 1'b1;
                        job.kind    = JOB_WRITE;
                        job.address = addr_ff;
                        job.data    = {wa_ff, in_byte};
                        if (aflags_ff[0]) addr_in = addr_ff + 32'd4;
                        written_in = written_ff + 14'd1;
                     end
                  end
                  wa_in = {wa_ff[15:0], in_byte};
               end
               if (in_last && !aflags_in[1] && pos_ff >= 16'd7) begin
                  job_push     = 1'b1;
                  job.kind     = JOB_HEADER;
                  job.address  = addr_in;
                  job.flags    = fbyte_in;
                  job.count    = remain_in;
                  job.request  = (remain_in != 14'd0);
                  if (job.request) begin
                     addr_step = addr_in + 32'd4;
                     if (aflags_in[0]) addr_in = addr_step;
                     phase_in = PH_WAIT;
                  end
               end
            end
            if (in_last)                pos_in = '0;
            else if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         cmd_ff     <= '0;
         aflags_ff  <= '0;
         fbyte_ff   <= '0;
         addr_ff    <= '0;
         len_ff     <= '0;
         wa_ff      <= '0;
         written_ff <= '0;
         remain_ff  <= '0;
         phase_ff   <= PH_PARSE;
      end else begin
         pos_ff     <= pos_in;
         cmd_ff     <= cmd_in;
         aflags_ff  <= aflags_in;
         fbyte_ff   <= fbyte_in;
         addr_ff    <= addr_in;
         len_ff     <= len_in;
         wa_ff      <= wa_in;
         written_ff <= written_in;
         remain_ff  <= remain_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

[src/prab_job_fifo.sv]
// Short job queue between the front and back ends.
module prab_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_job,
   input  prab_pkg::job_type push_data,
   input  logic              pop_job,
   output logic              full_q,
   output logic              valid_q,
   output prab_pkg::job_type head
);
   import prab_pkg::*;

   job_type              entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ff, wr_in;
   logic [JOB_PTR_W-1:0] rd_ff, rd_in;
   logic [JOB_PTR_W:0]   cnt_ff, cnt_in;

   assign full_q  = (cnt_ff == (JOB_PTR_W+1)'(JOB_DEPTH));
   assign valid_q = (cnt_ff != '0);
   assign head    = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push_job) wr_in = wr_ff + 1'b1;
      if (pop_job)  rd_in = rd_ff + 1'b1;
      if (push_job && !pop_job)      cnt_in = cnt_ff + 1'b1;
      else if (!push_job && pop_job) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_job) entry_ff[wr_ff] <= push_data;
   end

endmodule

[src/prab_back.sv]
// Back end: expands each job into result items, one per cycle unless pop stalls, into an output register.
module prab_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  prab_pkg::job_type job,
   output logic              job_pop,
   input  logic              pop,
   output logic              empty,
   output logic [1:0]        result_kind,
   output logic [7:0]        response_byte,
   output logic              response_last,
   output logic [31:0]       access_address,
   output logic [31:0]       access_data
);
   import prab_pkg::*;

   logic [3:0]  step_ff, step_in;
   logic        ovalid_ff, ovalid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;

   logic        emit;
   logic [3:0]  final_step;
   logic [15:0] total_len;

   assign emit      = job_valid && (!ovalid_ff || pop);
   assign total_len = {job.count, 2'b00} + 16'd7;

   always_comb begin
      case (job.kind)
         JOB_HEADER: final_step = job.request ? 4'd10 : 4'd9;
         JOB_RDATA:  final_step = job.request ? 4'd4 : 4'd3;
         default:    final_step = 4'd0;
      endcase
   end

   assign job_pop = emit && (step_ff == final_step);

   always_comb begin
      kind_in = RES_REPLY;
      byte_in = '0;
      last_in = 1'b0;
      addr_in = '0;
      data_in = '0;
      case (job.kind)
         JOB_ECHO: begin
            byte_in = job.byte_val;
            last_in = job.last;
         end
         JOB_WRITE: begin
            kind_in = RES_WRITE;
            addr_in = job.address;
            data_in = job.data;
         end
         JOB_HEADER: begin
            case (step_ff)
               4'd0: byte_in = REPLY_CMD;
               4'd1: byte_in = total_len[15:8];
               4'd2: byte_in = total_len[7:0];
               4'd3: byte_in = job.flags;
               4'd4: byte_in = job.address[31:24];
               4'd5: byte_in = job.address[23:16];
               4'd6: byte_in = job.address[15:8];
               4'd7: byte_in = job.address[7:0];
               4'd8: byte_in = {2'b00, job.count[13:8]};
               4'd9: begin
                  byte_in = job.count[7:0];
                  last_in = !job.request;
               end
               default: begin
                  kind_in = RES_READ;
                  addr_in = job.address;
               end
            endcase
         end
         default: begin
            // returned read word, big-endian, then the next read request
            case (step_ff)
               4'd0: byte_in = job.data[31:24];
               4'd1: byte_in = job.data[23:16];
               4'd2: byte_in = job.data[15:8];
               4'd3: begin
                  byte_in = job.data[7:0];
                  last_in = job.last;
               end
               default: begin
                  kind_in = RES_READ;
                  addr_in = job.address;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      step_in   = step_ff;
      ovalid_in = ovalid_ff && !pop;
      if (emit) begin
         ovalid_in = 1'b1;
         step_in   = job_pop ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
      end
   end

   assign empty          = !ovalid_ff;
   assign result_kind    = kind_ff;
   assign response_byte  = byte_ff;
   assign response_last  = last_ff;
   assign access_address = addr_ff;
   assign access_data    = data_ff;

endmodule

[src/packet_register_access_bridge.sv]
// Packet register access bridge: command packets in, reply bytes and bus accesses out.
//
// Input channel (push/full): one item per accepted edge, either a packet byte
// (req_item_kind 0, with req_in_byte and req_in_last) or a word returned by the
// bus for the outstanding read request (req_item_kind 1, req_read_data).
// Result channel (empty/pop): reply bytes, bus writes and bus read requests,
// selected by rsp_result_kind, oldest first.
// The front end parses one item per cycle while full is low, so packets stream in
// at one byte per cycle. Each item turns into at most one job in a 4-entry job
// queue; the back end drains a job at one result item per cycle while pop is not
// stalled (a reply header with its read request gives 11 result items, a returned
// word with its next request 5). With the back end idle, the first result of an
// item passes through the job queue and then the output register before it shows
// on the result ports. full rises only when the job queue fills, i.e. when the
// receiver stalls pop or a header or a returned word backs up the back end.
// Reset clears the parser to the start of a packet, empties the job queue and
// the output register; no results are pending after reset.
module packet_register_access_bridge (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_item_kind,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic [31:0] req_read_data,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_response_byte,
   output logic        rsp_response_last,
   output logic [31:0] rsp_access_address,
   output logic [31:0] rsp_access_data
);
   import prab_pkg::*;

   logic    accept;
   logic    job_push;
   job_type job_in;
   logic    job_pop;
   logic    job_valid;
   job_type job_head;

   assign accept = push && !full;

   prab_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item_kind (req_item_kind),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .read_data (req_read_data),
      .job_push  (job_push),
      .job       (job_in)
   );

   prab_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_job  (job_push),
      .push_data (job_in),
      .pop_job   (job_pop),
      .full_q    (full),
      .valid_q   (job_valid),
      .head      (job_head)
   );

   prab_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job            (job_head),
      .job_pop        (job_pop),
      .pop            (pop),
      .empty          (empty),
      .result_kind    (rsp_result_kind),
      .response_byte  (rsp_response_byte),
      .response_last  (rsp_response_last),
      .access_address (rsp_access_address),
      .access_data    (rsp_access_data)
   );

endmodule

[bench/prab_bus_checker.sv]
// Checker for the bridge: tracks accepted items, predicts result items and compares them.
`timescale 1ns / 100ps

module prab_bus_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_item_kind,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic [31:0] req_read_data,
   input  logic        empty,
   input  logic        pop,
   input  logic [1:0]  rsp_result_kind,
   input  logic [7:0]  rsp_response_byte,
   input  logic        rsp_response_last,
   input  logic [31:0] rsp_access_address,
   input  logic [31:0] rsp_access_data,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen
);
   import prab_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  rbyte;
      logic        rlast;
      logic [31:0] address;
      logic [31:0] data;
   } bus_result_type;

   bus_result_type expected_results[$];

   // parser state as the bridge should hold it
   logic [15:0] position;
   logic [7:0]  command;
   logic        write_mode;
   logic        auto_inc;
   logic [7:0]  flags_copy;
   logic [31:0] bus_address;
   logic [15:0] length;
   logic [23:0] assembly;
   logic [13:0] words_done;
   logic [13:0] words_left;
   logic        awaiting_data;
   int          error_total;
   int          compared;

   task automatic clear_parser();
      position      = '0;
      command       = '0;
      write_mode    = 1'b0;
      auto_inc      = 1'b0;
      flags_copy    = '0;
      bus_address   = '0;
      length        = '0;
      assembly      = '0;
      words_done    = '0;
      words_left    = '0;
      awaiting_data = 1'b0;
   endtask

   task automatic expect_result(input logic [1:0] kind, input logic [7:0] rbyte,
                                input logic rlast, input logic [31:0] addr,
                                input logic [31:0] data);
      bus_result_type r;
      r.kind    = kind;
      r.rbyte   = rbyte;
      r.rlast   = rlast;
      r.address = addr;
      r.data    = data;
      expected_results.push_back(r);
   endtask

   task automatic bump_address();
      if (auto_inc) begin
         bus_address = bus_address + 32'd4;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      error_total++;
      if (error_total <= 40) begin
         $display("%0t: result item %0d: %s got %0h expected %0h",
                  $time, compared, field, got, want);
      end
   endtask

   task automatic absorb_item(input logic returned_word, input logic [7:0] b,
                              input logic last, input logic [31:0] rd);
      int unsigned count;
      int unsigned owed;
      logic [15:0] reply_len;
      logic [7:0]  header [10];
      if (returned_word) begin
         // returned words only count while a read is in flight
         if (awaiting_data && words_left != 0) begin
            words_left = words_left - 14'd1;
            for (int i = 0; i < 4; i++) begin
               expect_result(RES_REPLY, rd[31 - 8*i -: 8], i == 3 && words_left == 0, '0, '0);
            end
            if (words_left != 0) begin
               expect_result(RES_READ, '0, 1'b0, bus_address, '0);
               bump_address();
            end else begin
               awaiting_data = 1'b0;
            end
         end
      end else if (!awaiting_data) begin
         if (position == 16'd0) begin
            clear_parser();
            command = b;
         end
         if (command == CMD_ECHO) begin
            expect_result(RES_REPLY, b, last, '0, '0);
         end else if (command == CMD_ACCESS) begin
            if (position == 16'd1 || position == 16'd2) begin
               length = {length[7:0], b};
            end else if (position == 16'd3) begin
               flags_copy = b;
               write_mode = b[7];
               auto_inc   = b[6];
            end else if (position >= 16'd4 && position <= 16'd7) begin
               bus_address = {bus_address[23:0], b};
            end else if (position >= 16'd8) begin
               if (position == 16'd9) begin
                  count = 32'({assembly[7:0], b});
                  words_left = (count > MAX_READ_WORDS) ? MAX_READ_WORDS : count[13:0];
               end
               // data starts at byte 8, so every position whose low two bits are 3 closes a word
               if (write_mode && position[1:0] == 2'd3) begin
                  owed = (length > 16'd5) ? 32'((length - 16'd5) / 16'd4) : 0;
                  if (words_done < owed) begin
                     expect_result(RES_WRITE, '0, 1'b0, bus_address, {assembly, b});
                     bump_address();
                     words_done = words_done + 14'd1;
                  end
               end
               assembly = {assembly[15:0], b};
            end
            if (last && !write_mode && position >= 16'd7) begin
               count     = 32'(words_left);
               reply_len = 16'(count * 4 + 7);
               header[0] = REPLY_CMD;
               header[1] = reply_len[15:8];
               header[2] = reply_len[7:0];
               header[3] = flags_copy;
               header[4] = bus_address[31:24];
               header[5] = bus_address[23:16];
               header[6] = bus_address[15:8];
               header[7] = bus_address[7:0];
               header[8] = {2'b00, words_left[13:8]};
               header[9] = words_left[7:0];
               for (int i = 0; i < 10; i++) begin
                  expect_result(RES_REPLY, header[i], i == 9 && count == 0, '0, '0);
               end
               if (count != 0) begin
                  expect_result(RES_READ, '0, 1'b0, bus_address, '0);
                  bump_address();
                  awaiting_data = 1'b1;
               end
            end
         end
         if (last) begin
            position = '0;
         end else if (position != 16'hFFFF) begin
            position = position + 16'd1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      bus_result_type want;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         // a result never stems from the item taken at the same edge, so compare first
         if (pop && !empty) begin
            compared++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item, kind", 32'(rsp_result_kind), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch("result_kind", 32'(rsp_result_kind), 32'(want.kind));
               if (rsp_response_byte !== want.rbyte)
                  report_mismatch("response_byte", 32'(rsp_response_byte), 32'(want.rbyte));
               if (rsp_response_last !== want.rlast)
                  report_mismatch("response_last", 32'(rsp_response_last), 32'(want.rlast));
               if (rsp_access_address !== want.address)
                  report_mismatch("access_address", rsp_access_address, want.address);
               if (rsp_access_data !== want.data)
                  report_mismatch("access_data", rsp_access_data, want.data);
            end
         end
         if (push && !full) begin
            absorb_item(req_item_kind, req_in_byte, req_in_last, req_read_data);
         end
      end
      mismatches   <= error_total;
      outstanding  <= expected_results.size();
      results_seen <= compared;
   end

endmodule

[bench/tb_packet_register_access_bridge.sv]
// Testbench top for the bridge: clock, reset, packet stimulus, result draining and verdict.
`timescale 1ns / 100ps

module tb_packet_register_access_bridge;
   import prab_pkg::*;

   localparam logic       ITEM_BYTE  = 1'b0;
   localparam logic       ITEM_WORD  = 1'b1;
   localparam logic [7:0] FLAG_WRITE = 8'h80;
   localparam logic [7:0] FLAG_INC   = 8'h40;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_item_kind;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic [31:0] req_read_data;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_response_byte;
   logic        rsp_response_last;
   logic [31:0] rsp_access_address;
   logic [31:0] rsp_access_data;
   int          mismatches;
   int          outstanding;
   int          results_seen;

   int          items_sent;
   int          packets_sent;
   int          idle_pct;
   logic [7:0]  pkt[$];

   packet_register_access_bridge dut (.*);

   prab_bus_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_len(input int longest);
      return ($urandom_range(0, 99) < 8) ? $urandom_range(8, longest) : $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] random_address();
      return ($urandom_range(0, 3) == 0) ? (32'hFFFF_FFF0 | $urandom_range(0, 15)) : $urandom();
   endfunction

   function automatic logic [15:0] write_length(input int payload);
      case ($urandom_range(0, 9))
         0, 1: return 16'($urandom_range(0, 5));
         2: return 16'hFFFF;
         3, 4: return 16'($urandom_range(6, 80));
         default: return 16'(payload + 5);
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [7:0] b, input logic last,
                            input logic [31:0] rd);
      if ($urandom_range(0, 99) < idle_pct) begin
         push <= 1'b0;
         repeat (pause_len(40)) @(posedge clock);
      end
      push          <= 1'b1;
      req_item_kind <= kind;
      req_in_byte   <= b;
      req_in_last   <= last;
      req_read_data <= rd;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt[i]) begin
         // a stray returned word while parsing must be ignored
         if ($urandom_range(0, 99) < 3) begin
            send_item(ITEM_WORD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom());
         end
         send_item(ITEM_BYTE, pkt[i], i == pkt.size() - 1, $urandom());
      end
      packets_sent++;
   endtask

   task automatic start_access(input logic [15:0] len, input logic [7:0] flags,
                               input logic [31:0] addr);
      pkt.delete();
      pkt.push_back(CMD_ACCESS);
      pkt.push_back(len[15:8]);
      pkt.push_back(len[7:0]);
      pkt.push_back(flags);
      for (int i = 3; i >= 0; i--) begin
         pkt.push_back(addr[8*i +: 8]);
      end
   endtask

   task automatic read_packet(input int total, input logic [15:0] count_field,
                              input logic [7:0] flags, input logic [31:0] addr,
                              input logic zero_fill, input logic stray);
      int words;
      start_access(16'($urandom_range(0, 65535)), flags & ~FLAG_WRITE, addr);
      if (total > 8) pkt.push_back(count_field[15:8]);
      if (total > 9) pkt.push_back(count_field[7:0]);
      while (pkt.size() < total) begin
         pkt.push_back(zero_fill ? 8'h00 : 8'($urandom_range(0, 255)));
      end
      words = (total < 10) ? 0 : (count_field > MAX_READ_WORDS) ? MAX_READ_WORDS : count_field;
      send_packet();
      if (words > 0) begin
         // bytes sent while the read is in flight are dropped
         if (stray) begin
            send_item(ITEM_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom());
         end
         repeat (words) begin
            send_item(ITEM_WORD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom());
         end
      end
   endtask

   task automatic write_packet(input int payload, input logic [15:0] len,
                               input logic [7:0] flags, input logic [31:0] addr);
      start_access(len, flags | FLAG_WRITE, addr);
      repeat (payload) pkt.push_back(8'($urandom_range(0, 255)));
      send_packet();
   endtask

   // receiver side: runs of pop with random stalls, sometimes long stall-free stretches
   initial begin : drain_side
      int run;
      pop = 1'b0;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 30);
         pop <= 1'b1;
         repeat (run) @(posedge clock);
         pop <= 1'b0;
         repeat (pause_len(60)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int pick;
      int plen;
      push          = 1'b0;
      req_item_kind = ITEM_BYTE;
      req_in_byte   = '0;
      req_in_last   = 1'b0;
      req_read_data = '0;
      reset         = 1'b1;
      idle_pct      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: echo, ignored word, read with wrapping address, one-word write
      pkt.delete();
      pkt.push_back(CMD_ECHO);
      pkt.push_back(8'hFF);
      send_packet();
      send_item(ITEM_WORD, 8'h00, 1'b0, 32'hFFFF_FFFF);
      read_packet(10, 16'd1, FLAG_INC | 8'h3F, 32'hFFFF_FFFC, 1'b0, 1'b1);
      write_packet(4, 16'd9, FLAG_INC, 32'h8000_0000);

      while (items_sent < 430) begin
         idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            pkt.delete();
            pkt.push_back(CMD_ECHO);
            repeat ($urandom_range(0, 9)) pkt.push_back(8'($urandom_range(0, 255)));
            send_packet();
         end else if (pick < 50) begin
            plen = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 13) : 10;
            read_packet(plen,
                        16'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 12)
                                                          : $urandom_range(0, 4)),
                        8'($urandom_range(0, 255)), random_address(), 1'b0,
                        $urandom_range(0, 3) == 0);
         end else if (pick < 80) begin
            plen = $urandom_range(0, 16);
            write_packet(plen, write_length(plen), 8'($urandom_range(0, 255)),
                         random_address());
         end else if (pick < 90) begin
            // truncated access packets and unknown commands
            pkt.delete();
            if ($urandom_range(0, 1) == 1) begin
               pkt.push_back(CMD_ACCESS);
               plen = $urandom_range(0, 6);
            end else begin
               pkt.push_back(8'($urandom_range(2, 255)));
               plen = $urandom_range(0, 11);
            end
            repeat (plen) pkt.push_back(8'($urandom_range(0, 255)));
            send_packet();
         end else begin
            repeat ($urandom_range(1, 2)) begin
               send_item(ITEM_WORD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         $urandom());
            end
         end
      end

      // word count beyond the maximum is clamped; the read is left in flight
      idle_pct = 5;
      start_access(16'($urandom_range(0, 65535)), FLAG_INC | 8'($urandom_range(0, 63)),
                   random_address());
      pkt.push_back(8'hFF);
      pkt.push_back(8'hFF);
      send_packet();

      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (24) @(posedge clock);

      $display("Drove %0d items in %0d packets, checked %0d result items",
               items_sent, packets_sent, results_seen);
      $display("Mix: echo, write, read, short and unknown packets, stray items, clamped count");
      if (outstanding != 0) begin
         $display("%0d expected result items never arrived", outstanding);
      end
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #(200_000_000);
      $display("Timeout: results stopped arriving");
      $display("== FAIL ==");
      $finish;
   end

endmodule
